// ===== sv/gbai_pkg.sv =====
package gbai_pkg;

	// field widths
	localparam int RAW_W   = 16;
	localparam int GAIN_W  = 24;
	localparam int TSTEP_W = 24;
	localparam int RATE_W  = 40;
	localparam int ANGLE_W = 48;
	localparam int CAL_W   = 10;

	// serial multiplier: upper product half, one guard bit over the rate
	localparam int PH_W = RATE_W + 1;

	// apb port
	localparam int DATA_W  = 32;
	localparam int PADDR_W = 4;

	localparam int NUM_AXES = 3;
	localparam logic [1:0] AXIS_LAST = 2'd2;

	// register reset values
	localparam logic [CAL_W-1:0]   CAL_SAMPLES_RST = 10'd200;
	localparam logic [GAIN_W-1:0]  RATE_GAIN_RST   = 24'd4000;
	localparam logic [TSTEP_W-1:0] TIME_STEP_RST   = 24'd83886;

	typedef enum logic [1:0] {
		REG_CAL_SAMPLES = 2'd0,
		REG_RATE_GAIN   = 2'd1,
		REG_TIME_STEP   = 2'd2
	} reg_idx_t;

	// item kind
	localparam logic KIND_MEASURE = 1'b0;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_MUL_A,
		ST_RATE,
		ST_MUL_B,
		ST_ANGLE,
		ST_ACC,
		ST_DLOAD,
		ST_DIV,
		ST_DWB,
		ST_DONE
	} state_t;

endpackage

// ===== sv/gbai_in_if.sv =====
interface gbai_in_if import gbai_pkg::*; ();
	logic valid;
	logic ready;
	logic kind;
	logic signed [RAW_W-1:0] raw_x;
	logic signed [RAW_W-1:0] raw_y;
	logic signed [RAW_W-1:0] raw_z;

	modport source (output valid, kind, raw_x, raw_y, raw_z, input ready);
	modport sink (input valid, kind, raw_x, raw_y, raw_z, output ready);
endinterface

// ===== sv/gbai_out_if.sv =====
interface gbai_out_if import gbai_pkg::*; ();
	logic valid;
	logic ready;
	logic signed [RATE_W-1:0]  rate_x;
	logic signed [RATE_W-1:0]  rate_y;
	logic signed [RATE_W-1:0]  rate_z;
	logic signed [ANGLE_W-1:0] angle_x;
	logic signed [ANGLE_W-1:0] angle_y;
	logic signed [ANGLE_W-1:0] angle_z;
	logic calibrating;

	modport source (output valid, rate_x, rate_y, rate_z, angle_x, angle_y, angle_z,
		calibrating, input ready);
	modport sink (input valid, rate_x, rate_y, rate_z, angle_x, angle_y, angle_z,
		calibrating, output ready);
endinterface

// ===== sv/gyro_bias_cal_and_angle_integrator.sv =====
// channel   dir  handshake     payload
// gyro      in   valid/ready   kind, raw_x, raw_y, raw_z
// result    out  valid/ready   rate_x/y/z, angle_x/y/z, calibrating
// apb       in   psel/penable  cal_samples @0x0, rate_gain @0x4, time_step @0x8
//
// one request at a time, taken only in idle; axes are handled one after another
// measure request: two 24-step shift-add multiplies
//   per axis share one 41-bit adder
// calibration sum request: each axis sample is added to its sum in turn
// calibration finish: each axis in turn through a restoring divider, one bit a step
// async active-low reset clears control, state and config; result register holds a finished
// request while the next one is taken, the sequencer waits in done while it is still full
module gyro_bias_cal_and_angle_integrator import gbai_pkg::*; #(
	parameter int COUNT_BITS = 10
) (
	input  logic               clk,
	input  logic               arst_n,
	gbai_in_if.sink            gyro,
	gbai_out_if.source         result,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0]  pwdata,
	output logic [DATA_W-1:0]  prdata,
	output logic               pready
);

	localparam int SUM_BITS = RAW_W + COUNT_BITS;
	localparam int CMP_W    = (COUNT_BITS > CAL_W) ? COUNT_BITS : CAL_W;
	localparam int STEP_N   = (SUM_BITS > GAIN_W) ? SUM_BITS : GAIN_W;
	localparam int STEP_W   = $clog2(STEP_N);
	localparam int SUM_W    = ANGLE_W + 1;
	localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
	localparam logic [ANGLE_W-1:0] ANG_MAX = {1'b0, {(ANGLE_W-1){1'b1}}};
	localparam logic [ANGLE_W-1:0] ANG_MIN = {1'b1, {(ANGLE_W-1){1'b0}}};

	// configuration registers
	logic [CAL_W-1:0]   cal_samples_q;
	logic [GAIN_W-1:0]  rate_gain_q;
	logic [TSTEP_W-1:0] time_step_q;

	// sequencer
	state_t              state_q, state_d;
	logic [1:0]          axis_q;
	logic [STEP_W-1:0]   step_q;

	// architectural state
	logic [RAW_W-1:0]      bias_q  [NUM_AXES];
	logic [SUM_BITS-1:0]   sum_q   [NUM_AXES];
	logic [COUNT_BITS-1:0] count_q;
	logic [RATE_W-1:0]     rate_q  [NUM_AXES];
	logic [ANGLE_W-1:0]    angle_q [NUM_AXES];

	// captured request
	logic [RAW_W-1:0] raw_q [NUM_AXES];

	// shift-add multiplier: product = {prod_hi_q, prod_lo_q}, multiplier shifts out of lo
	logic [PH_W-1:0]   mcand_q;
	logic [PH_W-1:0]   prod_hi_q;
	logic [GAIN_W-1:0] prod_lo_q;
	logic [PH_W-1:0]   add_hi;

	// restoring divider on the sum magnitude
	logic [SUM_BITS-1:0]   dq_q;
	logic [COUNT_BITS-1:0] rem_q;
	logic                  neg_q;
	logic [COUNT_BITS:0]   rem_sh;
	logic [COUNT_BITS:0]   rem_sub;
	logic                  fits;
	logic [SUM_BITS-1:0]   quot;

	// result register
	logic                 out_valid_q;
	logic [RATE_W-1:0]    out_rate_q  [NUM_AXES];
	logic [ANGLE_W-1:0]   out_angle_q [NUM_AXES];
	logic                 out_cal_q;

	// sequencer outputs
	logic in_ready_c;
	logic out_load_c;
	logic step_last;
	logic axis_last;
	logic acc_ok;

	// misc datapath
	logic [RAW_W-1:0]    diff;
	logic [SUM_W-1:0]    ang_sum;
	logic [ANGLE_W-1:0]  ang_sat;
	logic [SUM_BITS-1:0] sum_mag;
	logic                cfg_wr;
	reg_idx_t            cfg_idx;

	// ---------------------------------------------------------------- apb
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = reg_idx_t'(paddr[3:2]);

	always_comb begin
		unique case (cfg_idx)
			REG_CAL_SAMPLES: prdata = DATA_W'(cal_samples_q);
			REG_RATE_GAIN:   prdata = DATA_W'(rate_gain_q);
			REG_TIME_STEP:   prdata = DATA_W'(time_step_q);
			default:         prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_samples_q <= CAL_SAMPLES_RST;
			rate_gain_q   <= RATE_GAIN_RST;
			time_step_q   <= TIME_STEP_RST;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_CAL_SAMPLES: cal_samples_q <= pwdata[CAL_W-1:0];
				REG_RATE_GAIN:   rate_gain_q   <= pwdata[GAIN_W-1:0];
				REG_TIME_STEP:   time_step_q   <= pwdata[TSTEP_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------- datapath helpers
	// one multiplier bit per cycle: add the multiplicand if the lsb is set, then
	// shift the whole product right arithmetically
	assign add_hi = prod_hi_q + (prod_lo_q[0] ? mcand_q : '0);

	// one quotient bit per cycle
	assign rem_sh  = {rem_q, dq_q[SUM_BITS-1]};
	assign fits    = rem_sh >= {1'b0, count_q};
	assign rem_sub = rem_sh - {1'b0, count_q};
	assign quot    = neg_q ? (~dq_q + 1'b1) : dq_q;

	assign sum_mag = sum_q[axis_q][SUM_BITS-1] ? (~sum_q[axis_q] + 1'b1) : sum_q[axis_q];
	assign diff    = raw_q[axis_q] - bias_q[axis_q];

	// floored product >> 24 sits in prod_hi_q, add it and clamp to 48 bits
	assign ang_sum = {angle_q[axis_q][ANGLE_W-1], angle_q[axis_q]}
		+ {{(SUM_W-PH_W){prod_hi_q[PH_W-1]}}, prod_hi_q};
	assign ang_sat = (ang_sum[SUM_W-1] != ang_sum[SUM_W-2])
		? (ang_sum[SUM_W-1] ? ANG_MIN : ANG_MAX) : ang_sum[ANGLE_W-1:0];

	// keep summing while below the target and below the counter limit
	assign acc_ok = (CMP_W'(count_q) < CMP_W'(cal_samples_q)) && (count_q != CNT_MAX);

	assign step_last = (step_q == '0);
	assign axis_last = (axis_q == AXIS_LAST);

	// ---------------------------------------------------------------- sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (gyro.valid) begin
					if (gyro.kind == KIND_MEASURE)
						state_d = ST_LOAD;
					else if (acc_ok)
						state_d = ST_ACC;
					else
						state_d = ST_DLOAD;
				end
			end
			ST_LOAD:  state_d = ST_MUL_A;
			ST_MUL_A: if (step_last) state_d = ST_RATE;
			ST_RATE:  state_d = ST_MUL_B;
			ST_MUL_B: if (step_last) state_d = ST_ANGLE;
			ST_ANGLE: state_d = axis_last ? ST_DONE : ST_LOAD;
			ST_ACC:   state_d = axis_last ? ST_DONE : ST_ACC;
			ST_DLOAD: state_d = ST_DIV;
			ST_DIV:   if (step_last) state_d = ST_DWB;
			ST_DWB:   state_d = axis_last ? ST_DONE : ST_DLOAD;
			ST_DONE:  if (!out_valid_q || result.ready) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready_c = 1'b0;
		out_load_c = 1'b0;
		unique case (state_q)
			ST_IDLE: in_ready_c = 1'b1;
			ST_DONE: out_load_c = !out_valid_q || result.ready;
			default: ;
		endcase
	end

	assign gyro.ready = in_ready_c;

	// ---------------------------------------------------------------- control and state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			axis_q      <= '0;
			step_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			for (int a = 0; a < NUM_AXES; a++) begin
				bias_q[a]  <= '0;
				sum_q[a]   <= '0;
				rate_q[a]  <= '0;
				angle_q[a] <= '0;
			end
		end else begin
			state_q <= state_d;

			if (out_load_c)
				out_valid_q <= 1'b1;
			else if (result.ready)
				out_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					axis_q <= '0;
				end
				ST_LOAD: begin
					step_q <= STEP_W'(GAIN_W - 1);
				end
				ST_MUL_A, ST_MUL_B, ST_DIV: begin
					step_q <= step_q - 1'b1;
				end
				ST_RATE: begin
					rate_q[axis_q] <= {prod_hi_q[RAW_W-1:0], prod_lo_q};
					step_q         <= STEP_W'(TSTEP_W - 1);
				end
				ST_ANGLE: begin
					angle_q[axis_q] <= ang_sat;
					axis_q          <= axis_q + 1'b1;
				end
				ST_ACC: begin
					sum_q[axis_q] <= sum_q[axis_q]
						+ {{COUNT_BITS{raw_q[axis_q][RAW_W-1]}}, raw_q[axis_q]};
					axis_q <= axis_q + 1'b1;
					if (axis_last)
						count_q <= count_q + 1'b1;
				end
				ST_DLOAD: begin
					step_q <= STEP_W'(SUM_BITS - 1);
				end
				ST_DWB: begin
					// empty count at finish gives a zero offset
					bias_q[axis_q] <= (count_q == '0) ? '0 : quot[RAW_W-1:0];
					sum_q[axis_q]  <= '0;
					axis_q         <= axis_q + 1'b1;
					if (axis_last)
						count_q <= '0;
				end
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------- payload registers
	always_ff @(posedge clk) begin
		if (in_ready_c && gyro.valid) begin
			raw_q[0] <= gyro.raw_x;
			raw_q[1] <= gyro.raw_y;
			raw_q[2] <= gyro.raw_z;
		end

		unique case (state_q)
			ST_LOAD: begin
				// offset-corrected sample times gain
				mcand_q   <= {{(PH_W-RAW_W){diff[RAW_W-1]}}, diff};
				prod_hi_q <= '0;
				prod_lo_q <= rate_gain_q;
			end
			ST_MUL_A, ST_MUL_B: begin
				prod_hi_q <= {add_hi[PH_W-1], add_hi[PH_W-1:1]};
				prod_lo_q <= {add_hi[0], prod_lo_q[GAIN_W-1:1]};
			end
			ST_RATE: begin
				// rate times time step, upper half is the floored q.16 increment
				mcand_q   <= {prod_hi_q[RAW_W-1], prod_hi_q[RAW_W-1:0], prod_lo_q};
				prod_hi_q <= '0;
				prod_lo_q <= time_step_q;
			end
			ST_DLOAD: begin
				neg_q <= sum_q[axis_q][SUM_BITS-1];
				dq_q  <= sum_mag;
				rem_q <= '0;
			end
			ST_DIV: begin
				rem_q <= fits ? rem_sub[COUNT_BITS-1:0] : rem_sh[COUNT_BITS-1:0];
				dq_q  <= {dq_q[SUM_BITS-2:0], fits};
			end
			default: ;
		endcase

		if (out_load_c) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				out_rate_q[a]  <= rate_q[a];
				out_angle_q[a] <= angle_q[a];
			end
			out_cal_q <= (count_q != '0);
		end
	end

	assign result.valid       = out_valid_q;
	assign result.rate_x      = out_rate_q[0];
	assign result.rate_y      = out_rate_q[1];
	assign result.rate_z      = out_rate_q[2];
	assign result.angle_x     = out_angle_q[0];
	assign result.angle_y     = out_angle_q[1];
	assign result.angle_z     = out_angle_q[2];
	assign result.calibrating = out_cal_q;

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import gbai_pkg::*;

	localparam int COUNT_BITS = 10;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
	localparam longint ANGLE_MAX = (longint'(1) <<< (ANGLE_W - 1)) - 1;
	localparam longint ANGLE_MIN = -ANGLE_MAX - 1;
	localparam logic KIND_TICK = ~KIND_MEASURE;
	// no request or result for this many cycles means the block is stuck
	localparam int STALL_LIMIT = 3000;
	// pause after the last result before touching registers
	localparam int SETTLE_CYCLES = 16;
	// quiet window at the end, longer than one measure request
	localparam int TAIL_CYCLES = 200;

	typedef struct packed {
		logic kind;
		logic signed [RAW_W-1:0] raw_x;
		logic signed [RAW_W-1:0] raw_y;
		logic signed [RAW_W-1:0] raw_z;
	} gyro_req_t;

	typedef struct packed {
		logic [NUM_AXES-1:0][RATE_W-1:0]  rate;
		logic [NUM_AXES-1:0][ANGLE_W-1:0] angle;
		logic calibrating;
	} gyro_res_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic pready;

	gbai_in_if gyro_ch ();
	gbai_out_if result_ch ();

	gyro_bias_cal_and_angle_integrator #(.COUNT_BITS(COUNT_BITS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.gyro(gyro_ch),
		.result(result_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// predictor copy of the registers
	logic [CAL_W-1:0]   n_cal_set;
	logic [GAIN_W-1:0]  gain_set;
	logic [TSTEP_W-1:0] tstep_set;

	// predictor copy of the block state
	logic signed [RAW_W-1:0]            bias [NUM_AXES];
	logic signed [RAW_W+COUNT_BITS-1:0] bias_sum [NUM_AXES];
	logic [COUNT_BITS-1:0]              bias_count;
	longint                             rate_last [NUM_AXES];
	longint                             angle_now [NUM_AXES];

	gyro_req_t gyro_todo [$];    // requests not yet presented
	gyro_res_t result_due [$];   // predicted results in order
	gyro_req_t next_req;
	gyro_res_t got;
	gyro_res_t want;
	string axis_tag [NUM_AXES] = '{"x", "y", "z"};

	int req_driven = 0;
	int req_accepted = 0;
	int res_seen = 0;
	int n_mismatch = 0;
	int n_cal_done = 0;
	int n_clamp_hi = 0;
	int n_clamp_lo = 0;
	int quiet_cycles = 0;
	int gap_left = 0;
	int stall_left = 0;
	bit idle_on = 1'b1;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// advance the predicted state by one request and return its result
	function automatic gyro_res_t integrate_gyro(gyro_req_t req);
		logic signed [RAW_W-1:0] raw [NUM_AXES];
		logic signed [RAW_W-1:0] delta;
		longint prod;
		longint incr;
		longint acc;
		gyro_res_t res;
		raw[0] = req.raw_x;
		raw[1] = req.raw_y;
		raw[2] = req.raw_z;
		if (req.kind == KIND_TICK) begin
			// keep summing until the target count or the counter limit is hit
			if (bias_count < n_cal_set && bias_count < COUNT_MAX) begin
				for (int a = 0; a < NUM_AXES; a++)
					bias_sum[a] = bias_sum[a] + raw[a];
				bias_count = bias_count + 1'b1;
			end else begin
				// finish: mean truncated toward zero, zero when nothing was summed
				for (int a = 0; a < NUM_AXES; a++) begin
					if (bias_count != 0)
						bias[a] = RAW_W'(longint'(bias_sum[a]) / longint'(bias_count));
					else
						bias[a] = '0;
					bias_sum[a] = '0;
				end
				bias_count = '0;
				n_cal_done++;
			end
		end else begin
			for (int a = 0; a < NUM_AXES; a++) begin
				delta = raw[a] - bias[a];    // 16-bit wrap
				prod = longint'(delta) * longint'(gain_set);
				// Q.40 down to Q.16, rounded toward minus infinity
				incr = (prod * longint'(tstep_set)) >>> TSTEP_W;
				acc = angle_now[a] + incr;
				if (acc > ANGLE_MAX) begin
					acc = ANGLE_MAX;
					n_clamp_hi++;
				end else if (acc < ANGLE_MIN) begin
					acc = ANGLE_MIN;
					n_clamp_lo++;
				end
				rate_last[a] = prod;
				angle_now[a] = acc;
			end
		end
		for (int a = 0; a < NUM_AXES; a++) begin
			res.rate[a] = RATE_W'(rate_last[a]);
			res.angle[a] = ANGLE_W'(angle_now[a]);
		end
		res.calibrating = (bias_count != 0);
		return res;
	endfunction

	task automatic flag_mismatch(string what, longint want_v, longint got_v);
		n_mismatch++;
		if (n_mismatch <= 10)
			$display("mismatch on %s after %0d results: expected %0d, got %0d",
				what, res_seen, want_v, got_v);
	endtask

	function automatic void queue_req(logic kind, logic signed [RAW_W-1:0] x,
			logic signed [RAW_W-1:0] y, logic signed [RAW_W-1:0] z);
		gyro_req_t r;
		r.kind = kind;
		r.raw_x = x;
		r.raw_y = y;
		r.raw_z = z;
		gyro_todo.push_back(r);
	endfunction

	// raw sample biased toward the rails and small values
	function automatic logic signed [RAW_W-1:0] any_raw();
		case ($urandom_range(0, 7))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return RAW_W'($urandom_range(0, 31)) - 16'sd16;
			default: return RAW_W'($urandom);
		endcase
	endfunction

	// gain or time step, with both extremes
	function automatic logic [GAIN_W-1:0] any_scale();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return GAIN_W'($urandom_range(0, 70000));
			default: return GAIN_W'($urandom);
		endcase
	endfunction

	// n summing ticks with a few measure requests mixed in, then the finishing tick
	function automatic void queue_calibration(int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 5) == 0)
				queue_req(KIND_MEASURE, any_raw(), any_raw(), any_raw());
			queue_req(KIND_TICK, any_raw(), any_raw(), any_raw());
		end
		queue_req(KIND_TICK, any_raw(), any_raw(), any_raw());
	endfunction

	// wait until every request is in and every result is out, then let the block settle
	task automatic drain();
		do begin
			@(negedge clk);
		end while (gyro_todo.size() != 0 || req_accepted != req_driven ||
			result_due.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// apb write then read back; only called while the block is idle
	task automatic reg_write(reg_idx_t idx, logic [DATA_W-1:0] val);
		logic [DATA_W-1:0] held;
		held = '0;
		case (idx)
			REG_CAL_SAMPLES: begin
				n_cal_set = val[CAL_W-1:0];
				held = DATA_W'(n_cal_set);
			end
			REG_RATE_GAIN: begin
				gain_set = val[GAIN_W-1:0];
				held = DATA_W'(gain_set);
			end
			REG_TIME_STEP: begin
				tstep_set = val[TSTEP_W-1:0];
				held = DATA_W'(tstep_set);
			end
			default: ;
		endcase
		// setup then access for the write
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		// read setup, psel stays up
		@(negedge clk);
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== held)
			flag_mismatch("register readback", longint'(held), longint'(prdata));
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// request driver: valid gets at most one update per falling edge and is held while a request waits to be taken
	always @(negedge clk) begin
		if (arst_n && !(gyro_ch.valid && req_accepted != req_driven)) begin
			if (gap_left > 0) begin
				gap_left--;
				gyro_ch.valid <= 1'b0;
			end else if (gyro_todo.size() != 0) begin
				next_req = gyro_todo.pop_front();
				gyro_ch.kind <= next_req.kind;
				gyro_ch.raw_x <= next_req.raw_x;
				gyro_ch.raw_y <= next_req.raw_y;
				gyro_ch.raw_z <= next_req.raw_z;
				gyro_ch.valid <= 1'b1;
				req_driven++;
				// idle burst before the following request
				if (idle_on && $urandom_range(0, 4) == 0)
					gap_left = $urandom_range(1, 10);
			end else begin
				gyro_ch.valid <= 1'b0;
			end
		end
	end

	// result sink with random stall bursts
	always @(negedge clk) begin
		if (arst_n) begin
			if (stall_left > 0) begin
				stall_left--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
				if (idle_on && $urandom_range(0, 5) == 0)
					stall_left = $urandom_range(1, 10);
			end
		end
	end

	// monitors: predict on each accepted request, check each accepted result
	always @(posedge clk) begin
		if (arst_n) begin
			quiet_cycles++;
			if (gyro_ch.valid && gyro_ch.ready) begin
				req_accepted++;
				quiet_cycles = 0;
				result_due.push_back(integrate_gyro(gyro_req_t'({gyro_ch.kind,
					gyro_ch.raw_x, gyro_ch.raw_y, gyro_ch.raw_z})));
			end
			if (result_ch.valid && result_ch.ready) begin
				quiet_cycles = 0;
				res_seen++;
				if (result_due.size() == 0) begin
					flag_mismatch("unexpected result", 0, 1);
				end else begin
					want = result_due.pop_front();
					got.rate[0] = result_ch.rate_x;
					got.rate[1] = result_ch.rate_y;
					got.rate[2] = result_ch.rate_z;
					got.angle[0] = result_ch.angle_x;
					got.angle[1] = result_ch.angle_y;
					got.angle[2] = result_ch.angle_z;
					got.calibrating = result_ch.calibrating;
					for (int a = 0; a < NUM_AXES; a++) begin
						if (got.rate[a] !== want.rate[a])
							flag_mismatch({"rate_", axis_tag[a]},
								longint'($signed(want.rate[a])),
								longint'($signed(got.rate[a])));
						if (got.angle[a] !== want.angle[a])
							flag_mismatch({"angle_", axis_tag[a]},
								longint'($signed(want.angle[a])),
								longint'($signed(got.angle[a])));
					end
					if (got.calibrating !== want.calibrating)
						flag_mismatch("calibrating", longint'(want.calibrating),
							longint'(got.calibrating));
				end
			end
			// watchdog
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("no request or result for %0d cycles", STALL_LIMIT);
				$display("status: fail");
				$finish;
			end
		end
	end

	initial begin
		int rounds;
		// every input known from time zero
		arst_n = 1'b0;
		gyro_ch.valid = 1'b0;
		gyro_ch.kind = KIND_MEASURE;
		gyro_ch.raw_x = '0;
		gyro_ch.raw_y = '0;
		gyro_ch.raw_z = '0;
		result_ch.ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		n_cal_set = CAL_SAMPLES_RST;
		gain_set = RATE_GAIN_RST;
		tstep_set = TIME_STEP_RST;
		for (int a = 0; a < NUM_AXES; a++) begin
			bias[a] = '0;
			bias_sum[a] = '0;
			rate_last[a] = 0;
			angle_now[a] = 0;
		end
		bias_count = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: rails, all-ones writes, short calibration with a measure inside
		reg_write(REG_CAL_SAMPLES, 32'd4);
		reg_write(REG_RATE_GAIN, '1);
		reg_write(REG_TIME_STEP, '1);
		queue_req(KIND_MEASURE, 16'sh7fff, 16'sh8000, 16'sh0000);
		queue_req(KIND_MEASURE, 16'sh8000, 16'sh7fff, 16'shffff);
		queue_req(KIND_TICK, 16'sh7fff, 16'sh8000, 16'sh0005);
		queue_req(KIND_TICK, 16'sh7fff, 16'sh8000, 16'shfffb);
		queue_req(KIND_MEASURE, 16'sh0000, 16'sh0000, 16'sh0000);
		queue_req(KIND_TICK, 16'sh7ffe, 16'sh8001, 16'sh0003);
		queue_req(KIND_TICK, 16'sh7fff, 16'sh8000, 16'sh1234);
		queue_req(KIND_TICK, 16'sh0000, 16'sh0000, 16'sh0000);
		// offsets near the rails make the subtraction wrap
		queue_req(KIND_MEASURE, 16'sh8000, 16'sh7fff, 16'sh0000);
		queue_req(KIND_MEASURE, 16'sh7fff, 16'sh8000, 16'sh7fff);
		queue_req(KIND_MEASURE, 16'sh0001, 16'shffff, 16'sh0000);
		drain();

		// unit gain, zero time step; target lowered while sums are held
		reg_write(REG_CAL_SAMPLES, 32'd8);
		reg_write(REG_RATE_GAIN, 32'h0001_0000);
		reg_write(REG_TIME_STEP, 32'd0);
		repeat (5) queue_req(KIND_TICK, any_raw(), any_raw(), any_raw());
		drain();
		reg_write(REG_CAL_SAMPLES, 32'd2);
		queue_req(KIND_TICK, any_raw(), any_raw(), any_raw());
		queue_req(KIND_MEASURE, any_raw(), any_raw(), any_raw());
		drain();

		// zero target: a tick finishes at once and clears the offsets
		reg_write(REG_CAL_SAMPLES, 32'd0);
		queue_req(KIND_TICK, 16'sh1111, 16'sh2222, 16'sh3333);
		queue_req(KIND_TICK, 16'sh7fff, 16'sh8000, 16'sh7fff);
		queue_req(KIND_MEASURE, 16'sh7fff, 16'sh8000, 16'sh0000);
		drain();

		// saturation: full gain and step, x driven up and y driven down
		reg_write(REG_RATE_GAIN, '1);
		reg_write(REG_TIME_STEP, '1);
		queue_req(KIND_TICK, any_raw(), any_raw(), any_raw());
		rounds = 0;
		do begin
			repeat (40)
				queue_req(KIND_MEASURE, RAW_W'($urandom_range(32000, 32767)),
					-RAW_W'($urandom_range(32000, 32767)), any_raw());
			drain();
			rounds++;
		end while ((n_clamp_hi == 0 || n_clamp_lo == 0) && rounds < 20);
		// pull both axes back off the limits
		repeat (10)
			queue_req(KIND_MEASURE, -RAW_W'($urandom_range(1000, 32767)),
				RAW_W'($urandom_range(1000, 32767)), any_raw());
		drain();

		// longer calibration back at the reset scales
		reg_write(REG_CAL_SAMPLES, 32'd20);
		reg_write(REG_RATE_GAIN, 32'd4000);
		reg_write(REG_TIME_STEP, 32'd83886);
		queue_calibration(int'(n_cal_set));
		repeat (5) queue_req(KIND_MEASURE, any_raw(), any_raw(), any_raw());

		// random phases: short calibration, measures, then a few of either kind
		for (int ph = 0; ph < 10; ph++) begin
			drain();
			if (ph >= 7)
				idle_on = 1'b0;
			reg_write(REG_CAL_SAMPLES, $urandom_range(1, 12));
			reg_write(REG_RATE_GAIN, DATA_W'(any_scale()));
			reg_write(REG_TIME_STEP, DATA_W'(any_scale()));
			queue_calibration(int'(n_cal_set));
			repeat (10) queue_req(KIND_MEASURE, any_raw(), any_raw(), any_raw());
			repeat (3) queue_req(1'($urandom_range(0, 1)), any_raw(), any_raw(), any_raw());
		end

		drain();
		repeat (TAIL_CYCLES) @(negedge clk);
		$display("%0d requests and %0d results checked, %0d calibrations finished",
			req_accepted, res_seen, n_cal_done);
		$display("angle clamps: %0d at the top, %0d at the bottom", n_clamp_hi, n_clamp_lo);
		if (n_mismatch == 0 && result_due.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("%0d mismatches, %0d results never arrived", n_mismatch,
				result_due.size());
			$display("status: fail");
		end
		$finish;
	end

endmodule

// ===== files.f =====
sv/gbai_pkg.sv
sv/gbai_in_if.sv
sv/gbai_out_if.sv
sv/gyro_bias_cal_and_angle_integrator.sv
sim/testbench.sv
